// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/ebzd_pkg.sv =====
// Package: constants, key-schedule functions and sequencer states.
`timescale 1ns / 1ps

package ebzd_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] KEY_MULT  = 32'h08088405;
  localparam logic [31:0] SEED_ZERO = 32'h12345678;
  localparam logic [31:0] SEED_ONE  = 32'h23456789;
  localparam logic [31:0] SEED_TWO  = 32'h34567890;
  localparam logic [15:0] KS_MASK   = 16'hFFFD;
  localparam int unsigned PASS_LEN  = 20;

  localparam logic [7:0] PASS_BYTES [PASS_LEN] = '{
    8'h6F, 8'h66, 8'h4F, 8'h31, 8'h61, 8'h30, 8'h75, 8'h65, 8'h58, 8'h41,
    8'h3F, 8'h20, 8'h5B, 8'hFF, 8'h73, 8'h20, 8'h68, 8'h20, 8'h25, 8'h3F
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KS,
    ST_PT,
    ST_MUL,
    ST_K2,
    ST_DONE
  } ebzd_state_e;

  // One reflected CRC-32 byte step.
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, acc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ {8'd0, acc[31:8]};
  endfunction

  // Seeds run over the password; evaluated at elaboration only.
  function automatic logic [95:0] seed_keys();
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    k0 = SEED_ZERO;
    k1 = SEED_ONE;
    k2 = SEED_TWO;
    for (int i = 0; i < PASS_LEN; i++) begin
      k0 = crc_byte(k0, PASS_BYTES[i]);
      k1 = KEY_MULT * (k1 + {24'd0, k0[7:0]}) + 32'd1;
      k2 = crc_byte(k2, k1[31:24]);
    end
    return {k2, k1, k0};
  endfunction

  localparam logic [95:0] SEED_KEYS = seed_keys();
  localparam logic [31:0] INIT_K0   = SEED_KEYS[31:0];
  localparam logic [31:0] INIT_K1   = SEED_KEYS[63:32];
  localparam logic [31:0] INIT_K2   = SEED_KEYS[95:64];

endpackage

// ===== sv/even_byte_zip_stream_decrypt_top.sv =====
// Top level: even-byte traditional zip stream decryption.
//
//  channel    | direction | tdata              | tlast
//  s_axis     | in        | [7:0] cipher_byte  | last_byte
//  m_axis     | out       | [7:0] plain_byte   | end_of_buffer
//
// Odd-position item: accept, then output load.
// Even-position item: accept, keystream product, plaintext and key_zero,
// key_one product, key_one and key_two, output load; the one multiplier serves
// the keystream product and the key_one update in turn, one registered stage each.
// Reset loads the password-seeded keys; no clearing pass is needed.
// A result waiting on m_axis does not block accepting the next item; the
// sequencer holds in its last step until the output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module even_byte_zip_stream_decrypt_top
  import ebzd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] cipher_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] plain_byte
  output logic       m_axis_tlast_o
);

  ebzd_state_e state_q, state_d;

  logic [31:0] key0_q, key1_q, key2_q;
  logic        odd_q;
  logic [7:0]  cb_q;
  logic        last_q;
  logic [7:0]  pb_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  logic        in_acc;
  logic        out_load;
  logic [15:0] ks_v;
  logic [31:0] mul_a, mul_b, prod;
  logic [7:0]  pt_byte;
  logic [31:0] key1_next;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);
  assign ks_v     = (key2_q[15:0] & KS_MASK) | 16'd2;
  assign pt_byte  = cb_q ^ prod[15:8];
  assign key1_next = prod + 32'd1;

  ebzd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = odd_q ? ST_DONE : ST_KS;
      ST_KS:   state_d = ST_PT;
      ST_PT:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_K2;
      ST_K2:   state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_a = key1_q + {24'd0, key0_q[7:0]};
    mul_b = KEY_MULT;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_KS: begin
        mul_a = {16'd0, ks_v};
        mul_b = {16'd0, ks_v ^ 16'd1};
      end
      ST_PT, ST_MUL, ST_K2, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key0_q      <= INIT_K0;
      key1_q      <= INIT_K1;
      key2_q      <= INIT_K2;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PT) key0_q <= crc_byte(key0_q, pt_byte);
      if (state_q == ST_K2) begin
        key1_q <= key1_next;
        key2_q <= crc_byte(key2_q, key1_next[31:24]);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          key0_q <= INIT_K0;
          key1_q <= INIT_K1;
          key2_q <= INIT_K2;
          odd_q  <= 1'b0;
        end else begin
          odd_q  <= ~odd_q;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cb_q   <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
      pb_q   <= s_axis_tdata_i;
    end
    if (state_q == ST_PT) pb_q <= pt_byte;
    if (out_load) begin
      out_data_q <= pb_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  `ASSERT_NEXT(a_odd_skips_keys, clk_i, rst_ni, in_acc && odd_q, state_q == ST_DONE)
  `ASSERT_NEXT(a_last_reseeds, clk_i, rst_ni, out_load && last_q,
               key0_q == INIT_K0 && key2_q == INIT_K2 && !odd_q)
  `ASSERT_NEXT(a_odd_passes, clk_i, rst_ni, out_load && odd_q,
               m_axis_tdata_o == $past(cb_q))
  `ASSERT_IMPL(a_ready_idle_only, clk_i, rst_ni, state_q == ST_DONE, !s_axis_tready_o)

endmodule

// ===== sv/ebzd_mul.sv =====
// Shared 32x32 multiplier, low word of the product registered.
`timescale 1ns / 1ps

module ebzd_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_q;
  logic [31:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
